@@ hdl/extended_gcd_bezout_top_defines.svh @@
// Assertion macros used by the checker file of the extended GCD block.
`ifndef EXTENDED_GCD_BEZOUT_TOP_DEFINES_SVH
`define EXTENDED_GCD_BEZOUT_TOP_DEFINES_SVH

// Concurrent assertion on clk_i, switched off while rst_ni is low.
`define EBZ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion on clk_i that also holds during reset.
`define EBZ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/ebz_pkg.sv @@
package ebz_pkg;

  // Operand and coefficient widths.
  localparam int unsigned OpndW = 31;
  localparam int unsigned CoefW = OpndW + 1;
  localparam int unsigned CntW  = $clog2(OpndW);

  // One operand word.
  typedef struct packed {
    logic [OpndW-1:0] value_a;
    logic [OpndW-1:0] value_b;
  } ebz_in_t;

  // One result word.
  typedef struct packed {
    logic [OpndW-1:0]        gcd_value;
    logic signed [CoefW-1:0] coef_a;
    logic signed [CoefW-1:0] coef_b;
  } ebz_out_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_DONE
  } ebz_state_e;

endpackage

@@ hdl/extended_gcd_bezout_top.sv @@
// Extended Euclidean algorithm: gcd of two unsigned operands and the Bezout
// coefficients x, y with a*x + b*y = gcd, in two's complement.
// Channels: an operand word on operands_i is taken at a rising edge where
// start is high and busy is low. The result word on result_o is marked by
// done_o for exactly one cycle; the receiver must take it then.
// busy stays high from the accepting edge up to and including the done_o
// cycle, so only one word is in work at a time.
// Sequence: after the accepting edge the block runs Euclid steps until the
// remainder is zero, then shows the result. A step is one check state, a
// one-bit-per-cycle restoring divider over OpndW quotient bits and one
// update state. The divider also builds q * x and q * y by shift-and-add
// while the quotient bits come out, so no multiplier is needed. When b is
// zero the check state goes straight to done: gcd = a, x = 1, y = 0.
// A new word is taken only once the block is back in idle after done_o.
// Reset: the sequencer returns to idle, busy and done_o go low; a word in
// work is dropped.
module extended_gcd_bezout_top
  import ebz_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  ebz_in_t  operands_i,
  output logic     done_o,
  output ebz_out_t result_o
);

  ebz_state_e state_q, state_d;

  logic [OpndW-1:0] r_prev_q, r_prev_d;
  logic [OpndW-1:0] r_cur_q, r_cur_d;
  logic [CoefW-1:0] x_prev_q, x_prev_d;
  logic [CoefW-1:0] x_cur_q, x_cur_d;
  logic [CoefW-1:0] y_prev_q, y_prev_d;
  logic [CoefW-1:0] y_cur_q, y_cur_d;
  logic [OpndW-1:0] rem_q, rem_d;
  logic [OpndW-1:0] dvd_q, dvd_d;
  logic [CoefW-1:0] px_q, px_d;
  logic [CoefW-1:0] py_q, py_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic             accept;
  logic [OpndW:0]   rem_sh;
  logic [OpndW:0]   diff;
  logic             ge;

  assign accept = start && (state_q == ST_IDLE);

  // Shared divider slice: shift in one dividend bit and trial subtract.
  assign rem_sh = {rem_q, dvd_q[OpndW-1]};
  assign diff   = rem_sh - {1'b0, r_cur_q};
  assign ge     = (rem_sh >= {1'b0, r_cur_q});

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (r_cur_q == '0) state_d = ST_DONE;
        else               state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == '0) state_d = ST_UPDATE;
      end
      ST_UPDATE: state_d = ST_CHECK;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    r_prev_d = r_prev_q;
    r_cur_d  = r_cur_q;
    x_prev_d = x_prev_q;
    x_cur_d  = x_cur_q;
    y_prev_d = y_prev_q;
    y_cur_d  = y_cur_q;
    rem_d    = rem_q;
    dvd_d    = dvd_q;
    px_d     = px_q;
    py_d     = py_q;
    cnt_d    = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          r_prev_d = operands_i.value_a;
          r_cur_d  = operands_i.value_b;
          x_prev_d = CoefW'(1);
          x_cur_d  = '0;
          y_prev_d = '0;
          y_cur_d  = CoefW'(1);
        end
      end
      ST_CHECK: begin
        // Load the divider for the next quotient.
        rem_d = '0;
        dvd_d = r_prev_q;
        px_d  = '0;
        py_d  = '0;
        cnt_d = CntW'(OpndW - 1);
      end
      ST_DIV: begin
        // One quotient bit per cycle, MSB first; q*x and q*y by Horner.
        rem_d = ge ? diff[OpndW-1:0] : rem_sh[OpndW-1:0];
        dvd_d = {dvd_q[OpndW-2:0], 1'b0};
        px_d  = {px_q[CoefW-2:0], 1'b0} + (ge ? x_cur_q : '0);
        py_d  = {py_q[CoefW-2:0], 1'b0} + (ge ? y_cur_q : '0);
        cnt_d = cnt_q - CntW'(1);
      end
      ST_UPDATE: begin
        r_prev_d = r_cur_q;
        r_cur_d  = rem_q;
        x_prev_d = x_cur_q;
        x_cur_d  = x_prev_q - px_q;
        y_prev_d = y_cur_q;
        y_cur_d  = y_prev_q - py_q;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers carry no reset.
  always_ff @(posedge clk_i) begin
    r_prev_q <= r_prev_d;
    r_cur_q  <= r_cur_d;
    x_prev_q <= x_prev_d;
    x_cur_q  <= x_cur_d;
    y_prev_q <= y_prev_d;
    y_cur_q  <= y_cur_d;
    rem_q    <= rem_d;
    dvd_q    <= dvd_d;
    px_q     <= px_d;
    py_q     <= py_d;
    cnt_q    <= cnt_d;
  end

  // Handshake outputs.
  always_comb begin
    busy   = (state_q != ST_IDLE);
    done_o = (state_q == ST_DONE);
  end

  // The result word is read straight from the working registers.
  assign result_o.gcd_value = r_prev_q;
  assign result_o.coef_a    = x_prev_q;
  assign result_o.coef_b    = y_prev_q;

endmodule

@@ hdl/ebz_checker.sv @@
`include "extended_gcd_bezout_top_defines.svh"

// Port-level checks on the extended GCD block.
module ebz_checker
  import ebz_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     done_o,
  input ebz_out_t result_o
);

  // A result is only ever shown while a word is in work.
  `EBZ_ASSERT(a_done_busy, done_o |-> busy, "done_o without busy")

  // An accepted word keeps the block busy on the next cycle.
  `EBZ_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word not in work")

  // Each word yields one strobe, after which the block is free again.
  `EBZ_ASSERT(a_done_once, done_o |=> (!done_o && !busy), "strobe repeated or busy stuck")

  // A zero gcd only comes from two zero operands, giving x = 1 and y = 0.
  `EBZ_ASSERT(a_zero_gcd,
    (done_o && result_o.gcd_value == '0) |-> (result_o.coef_a == 1 && result_o.coef_b == 0),
    "bad coefficients for zero gcd")

  // No strobe while reset is held.
  `EBZ_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !done_o, "done_o during reset")

endmodule

bind extended_gcd_bezout_top ebz_checker u_ebz_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
